// ----- rtl/dppc_pkg.sv -----
// ----------------------------------------------------------------------------
// dppc_pkg
// Shared types and constants for the debounced pulse period capture block.
// ----------------------------------------------------------------------------
package dppc_pkg;

  localparam int BUFFER_DEPTH = 512;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ADDR_W       = IDX_W + 1;
  localparam int MEM_DEPTH    = 2 * BUFFER_DEPTH;
  localparam int TIME_W       = 32;
  localparam int DEB_W        = 20;
  localparam int MODE_W       = 2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = DEB_W'(5000);
  localparam logic [TIME_W-1:0] NO_PULSE_SINCE = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 176;

  localparam logic [MODE_W-1:0] MODE_PULSE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_SUMMARY = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // one queued operation: timestamp store, window summary or snapshot read
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] data;
    logic [TIME_W-1:0] pulse_count;
    logic [TIME_W-1:0] last_period_us;
    logic [TIME_W-1:0] since_last_us;
    logic [CNT_W-1:0]  stored_count;
    logic [TIME_W-1:0] dropped_count;
    logic              entry_valid;
  } op_entry_t;

endpackage

// ----- rtl/dppc_front.sv -----
// ----------------------------------------------------------------------------
// dppc_front
// Accepts input items, applies debounce, keeps window counters and turns
// stored pulses, closes and reads into queued operations for the back end.
// ----------------------------------------------------------------------------
module dppc_front
  import dppc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic [MODE_W-1:0]    s_axis_tuser,
  input  logic                 cfg_valid,
  input  logic [DEB_W-1:0]     cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output op_entry_t            q_push_entry
);

  logic [DEB_W-1:0]  debounce_us;
  logic              had_pulse;
  logic [TIME_W-1:0] last_accepted_time;
  logic [TIME_W-1:0] prev_accepted_time;
  logic [TIME_W-1:0] window_pulse_count;
  logic [CNT_W-1:0]  window_stored_count;
  logic [TIME_W-1:0] window_dropped_count;
  logic              active_bank;
  logic [CNT_W-1:0]  snapshot_count;

  logic              in_xfer;
  logic [MODE_W-1:0] mode;
  logic [TIME_W-1:0] now;
  logic [IDX_W-1:0]  entry_index;
  logic [TIME_W-1:0] since;
  logic              pulse_ok;
  logic              bank_room;

  assign s_axis_tready = !q_full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign mode          = s_axis_tuser;
  assign now           = s_axis_tdata[TIME_W-1:0];
  assign entry_index   = s_axis_tdata[TIME_W+IDX_W-1:TIME_W];
  assign since         = now - last_accepted_time;
  assign pulse_ok      = !had_pulse || (since >= {{(TIME_W-DEB_W){1'b0}}, debounce_us});
  assign bank_room     = window_stored_count < CNT_W'(BUFFER_DEPTH);

  always_comb begin
    q_push       = 1'b0;
    q_push_entry = '0;
    case (mode)
      MODE_PULSE: begin
        q_push            = in_xfer && pulse_ok && bank_room;
        q_push_entry.op   = OP_WRITE;
        q_push_entry.addr = {active_bank, window_stored_count[IDX_W-1:0]};
        q_push_entry.data = now;
      end
      MODE_CLOSE: begin
        q_push                      = in_xfer;
        q_push_entry.op             = OP_SUMMARY;
        q_push_entry.pulse_count    = window_pulse_count;
        q_push_entry.last_period_us = had_pulse ? (last_accepted_time - prev_accepted_time)
                                                : '0;
        q_push_entry.since_last_us  = had_pulse ? since : NO_PULSE_SINCE;
        q_push_entry.stored_count   = window_stored_count;
        q_push_entry.dropped_count  = window_dropped_count;
      end
      MODE_READ: begin
        q_push                   = in_xfer;
        q_push_entry.op          = OP_READ;
        q_push_entry.addr        = {!active_bank, entry_index};
        q_push_entry.entry_valid = {1'b0, entry_index} < snapshot_count;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us          <= DEBOUNCE_RESET;
      had_pulse            <= 1'b0;
      last_accepted_time   <= '0;
      prev_accepted_time   <= '0;
      window_pulse_count   <= '0;
      window_stored_count  <= '0;
      window_dropped_count <= '0;
      active_bank          <= 1'b0;
      snapshot_count       <= '0;
    end else begin
      if (cfg_valid) begin
        debounce_us <= cfg_data;
      end
      if (in_xfer && mode == MODE_PULSE && pulse_ok) begin
        prev_accepted_time <= had_pulse ? last_accepted_time : now;
        last_accepted_time <= now;
        had_pulse          <= 1'b1;
        window_pulse_count <= window_pulse_count + 1'b1;
        if (bank_room) begin
          window_stored_count <= window_stored_count + 1'b1;
        end else begin
          window_dropped_count <= window_dropped_count + 1'b1;
        end
      end else if (in_xfer && mode == MODE_CLOSE) begin
        snapshot_count       <= window_stored_count;
        active_bank          <= !active_bank;
        window_pulse_count   <= '0;
        window_stored_count  <= '0;
        window_dropped_count <= '0;
      end
    end
  end

  a_stored_bounded: assert property (@(posedge clk) disable iff (rst)
    window_stored_count <= CNT_W'(BUFFER_DEPTH))
    else $error("window stored count above buffer depth");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && mode == MODE_CLOSE |=> window_stored_count == '0 && window_pulse_count == '0)
    else $error("window counters not cleared on close");

endmodule

// ----- rtl/dppc_queue.sv -----
// ----------------------------------------------------------------------------
// dppc_queue
// Small register queue of operations between the front and back ends.
// ----------------------------------------------------------------------------
module dppc_queue
  import dppc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  op_entry_t push_entry,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output op_entry_t head
);

  op_entry_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("queue pop while empty");

endmodule

// ----- rtl/dppc_back.sv -----
// ----------------------------------------------------------------------------
// dppc_back
// Executes queued operations in order: stores timestamps into the bank
// memory, reads snapshot entries and drives the registered result stream.
// ----------------------------------------------------------------------------
module dppc_back
  import dppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  op_entry_t             head,
  output logic                  pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser
);

  logic [TIME_W-1:0] mem [MEM_DEPTH];
  logic [TIME_W-1:0] mem_rdata;

  logic              out_valid;
  logic              out_kind;
  logic [TIME_W-1:0] out_pulse_count;
  logic [TIME_W-1:0] out_last_period;
  logic [TIME_W-1:0] out_since_last;
  logic [CNT_W-1:0]  out_stored_count;
  logic [TIME_W-1:0] out_dropped_count;
  logic              out_entry_valid;
  logic              out_free;
  logic [TIME_W-1:0] entry_value;

  assign out_free = !out_valid || m_axis_tready;
  // stores never wait on the output; results need the output stage free
  assign pop      = head_valid && (head.op == OP_WRITE || out_free);

  always_ff @(posedge clk) begin
    if (pop && head.op == OP_WRITE) begin
      mem[head.addr] <= head.data;
    end
    if (pop && head.op == OP_READ) begin
      mem_rdata <= mem[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop && head.op != OP_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.op != OP_WRITE) begin
      out_kind          <= head.op == OP_READ;
      out_pulse_count   <= head.pulse_count;
      out_last_period   <= head.last_period_us;
      out_since_last    <= head.since_last_us;
      out_stored_count  <= head.stored_count;
      out_dropped_count <= head.dropped_count;
      out_entry_valid   <= head.entry_valid;
    end
  end

  assign entry_value   = out_entry_valid ? mem_rdata : '0;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {5'b0, out_entry_valid, entry_value, out_dropped_count,
                          out_stored_count, out_since_last, out_last_period,
                          out_pulse_count};

  a_summary_no_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_kind |-> !out_entry_valid)
    else $error("summary result carries an entry");

endmodule

// ----- rtl/debounced_pulse_period_capture.sv -----
// ----------------------------------------------------------------------------
// debounced_pulse_period_capture
// Debounced pulse timestamp capture with period, window summary and
// double-banked snapshot buffer.
// ----------------------------------------------------------------------------
// Takes one item per clock while the four-entry operation queue has room;
// the front end settles debounce, period and window counters in the cycle of
// the transfer, and the back end drains one queued operation per cycle into the
// 1024 x 32 bank memory (one port write or registered read) and the output
// register. A summary or entry result enters a queue slot at its input
// transfer, is offered from the output register once popped and completes
// when the output is ready. Pulses produce no result. A stalled output holds
// the queue at its first result operation; timestamp stores ahead of it still
// drain, and the input stalls once the four queue entries are filled.
module debounced_pulse_period_capture
  import dppc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // time_us, entry_index, zero pad
  input  logic [MODE_W-1:0]     s_axis_tuser,   // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pulse_count, last_period_us, since_last_us, stored_count, dropped_count,
  // entry_value, entry_valid, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,   // result_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DEB_W-1:0]      cfg_data        // debounce_us
);

  logic      q_full;
  logic      q_push;
  op_entry_t q_push_entry;
  logic      q_pop;
  logic      q_head_valid;
  op_entry_t q_head;

  assign cfg_ready = 1'b1;

  dppc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_entry  (q_push_entry)
  );

  dppc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  dppc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- test/debounced_pulse_period_capture_tb.sv -----
// ----------------------------------------------------------------------------
// debounced_pulse_period_capture_tb
// Self-checking bench: pulses, window closes and snapshot reads are driven on
// the input stream while a local model tracks debounce, period, counters and
// both timestamp banks, and every report on the output stream is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module debounced_pulse_period_capture_tb;
  import dppc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam logic              KIND_SUMMARY = 1'b0;
  localparam logic              KIND_ENTRY   = 1'b1;
  localparam int                SETTLE_CYCLES = QUEUE_DEPTH + 8;
  localparam int                HOLD_CYCLES   = 400;
  localparam int                STALL_LIMIT   = 4000;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] pulses;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] since;
    logic [CNT_W-1:0]  stored;
    logic [TIME_W-1:0] dropped;
    logic [TIME_W-1:0] value;
    logic              valid;
  } capture_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [DEB_W-1:0]      cfg_data = '0;

  // model state
  logic [DEB_W-1:0]  m_debounce;
  logic              m_had_pulse;
  logic [TIME_W-1:0] m_last_time;
  logic [TIME_W-1:0] m_prev_time;
  logic [TIME_W-1:0] m_pulses;
  logic [CNT_W-1:0]  m_stored;
  logic [TIME_W-1:0] m_dropped;
  logic [TIME_W-1:0] m_banks [2][BUFFER_DEPTH];
  logic              m_active;
  logic [CNT_W-1:0]  m_snap_count;

  capture_report_t pending_reports [$];
  int              mismatch_count = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  bit              hold_req = 1'b0;
  int              hold_left = 0;
  int              stall_cycles = 0;
  logic [TIME_W-1:0] now_us = '0;

  debounced_pulse_period_capture u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  task automatic model_reset();
    m_debounce   = DEBOUNCE_RESET;
    m_had_pulse  = 1'b0;
    m_last_time  = '0;
    m_prev_time  = '0;
    m_pulses     = '0;
    m_stored     = '0;
    m_dropped    = '0;
    m_active     = 1'b0;
    m_snap_count = '0;
  endtask

  task automatic predict_capture(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] t,
                                 input logic [IDX_W-1:0] idx);
    capture_report_t rep;
    rep = '0;
    case (mode)
      MODE_PULSE: begin
        if (!m_had_pulse || (t - m_last_time) >= TIME_W'(m_debounce)) begin
          m_prev_time = m_had_pulse ? m_last_time : t;
          m_last_time = t;
          m_had_pulse = 1'b1;
          if (m_stored < CNT_W'(BUFFER_DEPTH)) begin
            m_banks[m_active][m_stored[IDX_W-1:0]] = t;
            m_stored = m_stored + 1'b1;
          end else begin
            m_dropped = m_dropped + 1;
          end
          m_pulses = m_pulses + 1;
        end
      end
      MODE_CLOSE: begin
        rep.kind    = KIND_SUMMARY;
        rep.pulses  = m_pulses;
        rep.period  = m_had_pulse ? m_last_time - m_prev_time : '0;
        rep.since   = m_had_pulse ? t - m_last_time : NO_PULSE_SINCE;
        rep.stored  = m_stored;
        rep.dropped = m_dropped;
        pending_reports.push_back(rep);
        m_snap_count = m_stored;
        m_active     = ~m_active;
        m_pulses     = '0;
        m_stored     = '0;
        m_dropped    = '0;
      end
      MODE_READ: begin
        rep.kind = KIND_ENTRY;
        if (CNT_W'(idx) < m_snap_count) begin
          rep.value = m_banks[~m_active][idx];
          rep.valid = 1'b1;
        end
        pending_reports.push_back(rep);
      end
      default: ;  // unused mode does nothing
    endcase
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] t,
                           input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-TIME_W-IDX_W){1'b0}}, idx, t};
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_capture(mode, t, idx);
    @(negedge clk);
  endtask

  task automatic send_pulse(input logic [TIME_W-1:0] t);
    send_item(MODE_PULSE, t, IDX_W'($urandom));
  endtask

  task automatic send_close(input logic [TIME_W-1:0] t);
    send_item(MODE_CLOSE, t, IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    send_item(MODE_READ, $urandom, idx);
  endtask

  // stop sending and wait until every predicted report has come back
  task automatic wait_reports();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_debounce(input logic [DEB_W-1:0] value);
    wait_reports();
    // pulses give no report but may still be draining into the banks
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    m_debounce = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      if (mismatch_count < 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    capture_report_t want;
    capture_report_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind    = m_axis_tuser;
      got.pulses  = m_axis_tdata[31:0];
      got.period  = m_axis_tdata[63:32];
      got.since   = m_axis_tdata[95:64];
      got.stored  = m_axis_tdata[105:96];
      got.dropped = m_axis_tdata[137:106];
      got.value   = m_axis_tdata[169:138];
      got.valid   = m_axis_tdata[170];
      if (pending_reports.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected report, kind %0d", got.kind);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("result_kind", TIME_W'(want.kind), TIME_W'(got.kind));
        check_field("pulse_count", want.pulses, got.pulses);
        check_field("last_period_us", want.period, got.period);
        check_field("since_last_us", want.since, got.since);
        check_field("stored_count", TIME_W'(want.stored), TIME_W'(got.stored));
        check_field("dropped_count", want.dropped, got.dropped);
        check_field("entry_value", want.value, got.value);
        check_field("entry_valid", TIME_W'(want.valid), TIME_W'(got.valid));
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_read(IDX_W'(0));                     // nothing captured yet
    send_read(IDX_W'(BUFFER_DEPTH-1));
    send_close(32'd100);                      // no pulse ever
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, IDX_W'(BUFFER_DEPTH-1));
    send_pulse(32'hFFFF_F000);                // first pulse, period 0
    send_close(32'hFFFF_F010);
    send_pulse(32'hFFFF_F001);                // inside debounce
    send_pulse(32'hFFFF_F000 + 32'd4999);     // one short of debounce, wraps
    send_pulse(32'hFFFF_F000 + 32'd5000);     // exactly at debounce
    send_close(32'hFFFF_F000 + 32'd5010);
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_read(IDX_W'(2));
    send_read(IDX_W'(BUFFER_DEPTH-1));
    send_pulse(32'h0000_0000);
    send_pulse(32'hFFFF_FFFF);
    send_close(32'hFFFF_FFFF);
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_close(32'h0000_0000);                // empty window keeps last pulse
    send_read(IDX_W'(0));
    send_item(MODE_UNUSED, 32'h0000_0000, IDX_W'(0));
  endtask

  task automatic test_debounce_extremes();
    write_debounce('0);
    send_pulse(32'd50);                       // zero debounce accepts repeats
    send_pulse(32'd50);
    send_pulse(32'd50);
    send_pulse(32'd51);
    send_close(32'd60);
    for (int i = 0; i < 5; i++) send_read(IDX_W'(i));
    write_debounce('1);
    send_pulse(32'hFFFF_0000);
    send_pulse(32'hFFFF_0000 + 32'hF_FFFE);
    send_pulse(32'hFFFF_0000 + 32'hF_FFFF);
    send_close(32'h0010_0000);
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_read(IDX_W'(2));
  endtask

  task automatic test_full_bank();
    logic [TIME_W-1:0] base;
    base = $urandom;
    write_debounce('0);
    for (int i = 0; i < BUFFER_DEPTH + 18; i++) send_pulse(base + TIME_W'(3 * i));
    send_close(base + 32'd5000);
    send_read(IDX_W'(BUFFER_DEPTH-1));
    send_read(IDX_W'(0));
    send_read(IDX_W'(BUFFER_DEPTH/2));
    for (int i = 0; i < 30; i++) send_read(IDX_W'($urandom));
    send_close(base + 32'd6000);
  endtask

  task automatic test_output_stall();
    set_idling(0, 0);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      case (i % 4)
        0:       send_close(now_us + TIME_W'(i));
        1:       send_pulse(now_us + TIME_W'(i));
        default: send_read(IDX_W'($urandom_range(0, 3)));
      endcase
    end
    wait_reports();
    @(negedge clk);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct,
                              input logic [DEB_W-1:0] debounce, input int items);
    int sent;
    int pick;
    set_idling(send_pct, recv_pct);
    write_debounce(debounce);
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        if ($urandom_range(9) == 0)
          now_us = $urandom;
        else
          now_us = now_us + $urandom_range(0, 2 * int'(debounce) + 4);
        send_pulse(now_us);
      end else if (pick < 76) begin
        now_us = now_us + $urandom_range(0, int'(debounce) + 4);
        send_close(now_us);
      end else if (pick < 98) begin
        if (m_snap_count != 0 && $urandom_range(4) != 0)
          send_read(IDX_W'($urandom_range(0, int'(m_snap_count) - 1)));
        else
          send_read(IDX_W'($urandom));
      end else begin
        send_item(MODE_UNUSED, $urandom, IDX_W'($urandom));
        sent--;  // ignored items are not counted
      end
      sent++;
    end
  endtask

  task automatic test_random();
    random_phase(19, 58, DEB_W'($urandom_range(0, 64)), 400);
    random_phase(58, 19, DEB_W'($urandom_range(1000, 2 ** DEB_W - 1)), 400);
    random_phase(0, 0, DEBOUNCE_RESET, 400);
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idling(19, 58);
    test_directed();
    test_debounce_extremes();
    set_idling(58, 19);
    test_full_bank();
    test_output_stall();
    test_random();

    wait_reports();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- debounced_pulse_period_capture.f -----
rtl/dppc_pkg.sv
rtl/dppc_front.sv
rtl/dppc_queue.sv
rtl/dppc_back.sv
rtl/debounced_pulse_period_capture.sv
test/debounced_pulse_period_capture_tb.sv
